[sv/pbwe_pkg.sv]
`timescale 1ns / 1ps
// Package for the postfix bitwise word evaluator: token and error codes,
// register indexes, fixed field widths and the configuration struct.
// No dependencies.
package pbwe_pkg;

   localparam int WORD_BITS_DEF   = 32;
   localparam int STACK_DEPTH_DEF = 16;
   localparam int MAX_WORDS       = 1024;
   localparam int MAX_LAYERS      = 16;

   localparam int ACTION_W = 4;
   localparam int LAYER_W  = 4;
   localparam int LCOUNT_W = 5;
   localparam int WIDX_W   = 10;
   localparam int ERR_W    = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;

   typedef enum logic [ACTION_W-1:0] {
      ACT_AND    = 4'd0,
      ACT_OR     = 4'd1,
      ACT_XOR    = 4'd2,
      ACT_NOT    = 4'd3,
      ACT_CUR    = 4'd4,
      ACT_SHIP   = 4'd5,
      ACT_PLANET = 4'd6,
      ACT_ZERO   = 4'd7,
      ACT_ONES   = 4'd8,
      ACT_LAYER  = 4'd9
   } action_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE  = 3'd0,
      ERR_UNDER = 3'd1,
      ERR_LAYER = 3'd2,
      ERR_DEPTH = 3'd3,
      ERR_OVER  = 3'd4
   } error_type;

   localparam logic [CSR_IDX_W-1:0] CSR_IS_PLANET   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LAYER_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LAST_WORD   = 2'd2;

   typedef struct packed {
      logic                is_planet;
      logic [LCOUNT_W-1:0] layer_count;
      logic [WIDX_W-1:0]   last_word_index;
   } cfg_type;

endpackage

[sv/pbwe_ifs.sv]
`timescale 1ns / 1ps
// Channel interfaces of the evaluator: token input, result output and
// register write. Depends on pbwe_pkg.
interface pbwe_req_if import pbwe_pkg::*; #(parameter int WORD_BITS = WORD_BITS_DEF) ();
   logic                 valid;
   logic                 ready;
   logic [ACTION_W-1:0]  action;
   logic [LAYER_W-1:0]   layer_number;
   logic [WORD_BITS-1:0] operand_word;
   logic                 last_token;

   modport source (output valid, action, layer_number, operand_word, last_token,
                   input ready);
   modport sink   (input valid, action, layer_number, operand_word, last_token,
                   output ready);
endinterface

interface pbwe_rsp_if import pbwe_pkg::*; #(parameter int WORD_BITS = WORD_BITS_DEF) ();
   logic                 valid;
   logic                 ready;
   logic [WORD_BITS-1:0] result_word;
   logic [ERR_W-1:0]     error_code;
   logic [WIDX_W-1:0]    word_index;
   logic                 last_word;

   modport source (output valid, result_word, error_code, word_index, last_word,
                   input ready);
   modport sink   (input valid, result_word, error_code, word_index, last_word,
                   output ready);
endinterface

interface pbwe_csr_if import pbwe_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[sv/postfix_bitwise_word_evaluator.sv]
`timescale 1ns / 1ps
// Postfix bitwise word evaluator, top level: configuration registers,
// token execution and the stack memory. Depends on pbwe_pkg, pbwe_ifs,
// pbwe_exec and pbwe_stack_mem.
//
// Usage:
//  - req_chan carries one program token per transaction; the feeder repeats
//    the program for every word index and marks its final token.
//  - rsp_chan gives one transaction per final token: result word, error
//    code, word index and a flag for the final word of the run.
//  - csr_chan writes is_planet, layer_count and last_word_index; it is
//    always ready. Write only while no token is outstanding.
//  - Throughput is one token per cycle while rsp_chan does not stall.
//    A final token's result shows on rsp_chan the cycle after acceptance.
//  - The top of stack lives in a register; the entry below it is
//    prefetched from the stack memory every cycle, so the registered
//    memory read is hidden and a push forwards its spill.
//  - When the receiver stalls, the result register holds its transaction
//    and req_chan stalls for as long as that transaction waits.
//  - Reset empties the stack, clears the sticky error, the word counter
//    and the configuration registers; the stack memory needs no clearing.
module postfix_bitwise_word_evaluator import pbwe_pkg::*; #(
   parameter int WORD_BITS   = WORD_BITS_DEF,
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   pbwe_req_if.sink    req_chan,
   pbwe_rsp_if.source  rsp_chan,
   pbwe_csr_if.sink    csr_chan
);

   localparam int AW = $clog2(STACK_DEPTH);

   cfg_type              cfg_ff;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [AW-1:0]        rd_addr;
   logic [WORD_BITS-1:0] wr_data;
   logic [WORD_BITS-1:0] nos_word;

   // register writes always complete; unknown indexes drop
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_IS_PLANET:   cfg_ff.is_planet       <= csr_chan.data[0];
            CSR_LAYER_COUNT: cfg_ff.layer_count     <= csr_chan.data[LCOUNT_W-1:0];
            CSR_LAST_WORD:   cfg_ff.last_word_index <= csr_chan.data[WIDX_W-1:0];
            default: begin
            end
         endcase
      end
   end

   pbwe_exec #(
      .WORD_BITS   (WORD_BITS),
      .STACK_DEPTH (STACK_DEPTH)
   ) u_exec (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req      (req_chan),
      .rsp      (rsp_chan),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_addr  (rd_addr),
      .nos_word (nos_word)
   );

   pbwe_stack_mem #(
      .WORD_BITS   (WORD_BITS),
      .STACK_DEPTH (STACK_DEPTH)
   ) u_stack_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (nos_word)
   );

endmodule

[sv/pbwe_stack_mem.sv]
`timescale 1ns / 1ps
// Word stack memory: one write port, one registered read port, with
// write-to-read forwarding. Depends on pbwe_pkg.
module pbwe_stack_mem import pbwe_pkg::*; #(
   parameter int WORD_BITS   = WORD_BITS_DEF,
   parameter int STACK_DEPTH = STACK_DEPTH_DEF,
   localparam int AW         = $clog2(STACK_DEPTH)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  logic [WORD_BITS-1:0] wr_data,
   input  logic [AW-1:0]        rd_addr,
   output logic [WORD_BITS-1:0] rd_data
);

   logic [WORD_BITS-1:0] ram [STACK_DEPTH];
   logic [WORD_BITS-1:0] ram_q_ff;
   logic [WORD_BITS-1:0] fwd_data_ff;
   logic                 fwd_ff;
   logic                 fwd_in;

   assign fwd_in = wr_en && (wr_addr == rd_addr);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram[wr_addr] <= wr_data;
      end
      ram_q_ff    <= ram[rd_addr];
      fwd_data_ff <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else begin
         fwd_ff <= fwd_in;
      end
   end

   // same-cycle write to the entry being read wins
   assign rd_data = fwd_ff ? fwd_data_ff : ram_q_ff;

endmodule

[sv/pbwe_exec.sv]
`timescale 1ns / 1ps
// Token execution: top-of-stack register, stack pointer, sticky error,
// word counter and the result register. Depends on pbwe_pkg and pbwe_ifs.
module pbwe_exec import pbwe_pkg::*; #(
   parameter int WORD_BITS   = WORD_BITS_DEF,
   parameter int STACK_DEPTH = STACK_DEPTH_DEF,
   localparam int AW         = $clog2(STACK_DEPTH),
   localparam int SPW        = $clog2(STACK_DEPTH + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cfg_type              cfg,
   pbwe_req_if.sink             req,
   pbwe_rsp_if.source           rsp,
   output logic                 wr_en,
   output logic [AW-1:0]        wr_addr,
   output logic [WORD_BITS-1:0] wr_data,
   output logic [AW-1:0]        rd_addr,
   input  logic [WORD_BITS-1:0] nos_word
);

   logic [WORD_BITS-1:0] tos_ff, tos_in, tos_nx, push_val;
   logic [SPW-1:0]       sp_ff, sp_in, sp_nx, sp_rd;
   error_type            err_ff, err_in, err_tok, err_all, err_fin;
   logic [WIDX_W-1:0]    cnt_ff, cnt_in, final_index;
   logic                 final_word, accept, do_push;
   logic [LCOUNT_W-1:0]  layer_avail;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WORD_BITS-1:0] rsp_word_ff;
   error_type            rsp_err_ff;
   logic [WIDX_W-1:0]    rsp_idx_ff;
   logic                 rsp_last_ff;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   assign layer_avail = (cfg.layer_count < LCOUNT_W'(MAX_LAYERS)) ?
                        cfg.layer_count : LCOUNT_W'(MAX_LAYERS);
   assign final_index = (cfg.last_word_index < WIDX_W'(MAX_WORDS - 1)) ?
                        cfg.last_word_index : WIDX_W'(MAX_WORDS - 1);
   assign final_word  = cnt_ff >= final_index;

   // decode one token against the current stack top
   always_comb begin
      tos_nx   = tos_ff;
      sp_nx    = sp_ff;
      err_tok  = ERR_NONE;
      do_push  = 1'b0;
      push_val = '0;
      if (err_ff == ERR_NONE) begin
         case (action_type'(req.action))
            ACT_AND, ACT_OR, ACT_XOR: begin
               if (sp_ff < SPW'(2)) begin
                  err_tok = ERR_UNDER;
               end else begin
                  sp_nx = sp_ff - SPW'(1);
                  if (action_type'(req.action) == ACT_AND) begin
                     tos_nx = nos_word & tos_ff;
                  end else if (action_type'(req.action) == ACT_OR) begin
                     tos_nx = nos_word | tos_ff;
                  end else begin
                     tos_nx = nos_word ^ tos_ff;
                  end
               end
            end
            ACT_NOT: begin
               if (sp_ff == '0) begin
                  err_tok = ERR_UNDER;
               end else begin
                  tos_nx = ~tos_ff;
               end
            end
            ACT_CUR: begin
               do_push  = 1'b1;
               push_val = req.operand_word;
            end
            ACT_SHIP: begin
               do_push  = 1'b1;
               push_val = cfg.is_planet ? '0 : '1;
            end
            ACT_PLANET: begin
               do_push  = 1'b1;
               push_val = cfg.is_planet ? '1 : '0;
            end
            ACT_ZERO: begin
               do_push  = 1'b1;
               push_val = '0;
            end
            ACT_ONES: begin
               do_push  = 1'b1;
               push_val = '1;
            end
            ACT_LAYER: begin
               if ({1'b0, req.layer_number} < layer_avail) begin
                  do_push  = 1'b1;
                  push_val = req.operand_word;
               end else begin
                  err_tok = ERR_LAYER;
               end
            end
            default: begin
               err_tok = ERR_LAYER;
            end
         endcase
         if (do_push) begin
            if (sp_ff >= SPW'(STACK_DEPTH)) begin
               err_tok = ERR_OVER;
               do_push = 1'b0;
            end else begin
               tos_nx = push_val;
               sp_nx  = sp_ff + SPW'(1);
            end
         end
      end
   end

   // spill the old top into memory on a push
   assign wr_en   = accept && do_push && (sp_ff != '0);
   assign wr_addr = AW'(sp_ff - SPW'(1));
   assign wr_data = tos_ff;

   assign err_all = (err_ff != ERR_NONE) ? err_ff : err_tok;
   assign err_fin = (err_all == ERR_NONE && sp_nx != SPW'(1)) ? ERR_DEPTH : err_all;

   always_comb begin
      tos_in       = tos_ff;
      sp_in        = sp_ff;
      err_in       = err_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      if (accept) begin
         tos_in = tos_nx;
         sp_in  = sp_nx;
         err_in = err_all;
         if (req.last_token) begin
            sp_in        = '0;
            rsp_valid_in = 1'b1;
            err_in       = final_word ? ERR_NONE : err_fin;
            cnt_in       = final_word ? '0 : cnt_ff + WIDX_W'(1);
         end
      end
   end

   // prefetch the entry under the next top
   assign sp_rd   = sp_in - SPW'(2);
   assign rd_addr = sp_rd[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff        <= '0;
         err_ff       <= ERR_NONE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sp_ff        <= sp_in;
         err_ff       <= err_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tos_ff <= tos_in;
      if (accept && req.last_token) begin
         rsp_word_ff <= (err_fin == ERR_NONE) ? tos_nx : '0;
         rsp_err_ff  <= err_fin;
         rsp_idx_ff  <= cnt_ff;
         rsp_last_ff <= final_word;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.result_word = rsp_word_ff;
   assign rsp.error_code  = rsp_err_ff;
   assign rsp.word_index  = rsp_idx_ff;
   assign rsp.last_word   = rsp_last_ff;

endmodule
